// ===== hw/rtl/dls_pkg.sv =====
// Shared types and constants for the dust level smoother.
// No dependencies; imported by every module of the block.
package dls_pkg;

  localparam int SAMPLE_BITS       = 10;
  localparam int DEF_WINDOW_DEPTH  = 12;
  localparam int LEVEL_BITS        = 12;
  localparam int IVL_BITS          = 5;
  localparam int CFG_IDX_BITS      = 3;
  localparam int CLASS_BITS        = 2;

  localparam int SCALE_MUL         = 3500;
  localparam int SCALE_SHIFT       = 10;
  localparam int MUL_BITS          = SAMPLE_BITS + 12;
  localparam int TGT_RAW_BITS      = MUL_BITS - SCALE_SHIFT;
  localparam int STEP_DIV          = 10;
  localparam int FAR_STEP          = 12;
  localparam int FAR_DEC           = FAR_STEP / 2 + 1;

  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX      = '1;
  localparam logic [LEVEL_BITS-1:0] RST_FAIR       = 12'd110;
  localparam logic [LEVEL_BITS-1:0] RST_BAD        = 12'd210;
  localparam logic [LEVEL_BITS-1:0] RST_CEILING    = 12'd532;
  localparam logic [LEVEL_BITS-1:0] RST_FAR_LIMIT  = 12'd100;
  localparam logic [IVL_BITS-1:0]   RST_NEAR_IVL   = 5'd20;
  localparam logic [IVL_BITS-1:0]   RST_FAR_IVL    = 5'd7;

  localparam logic [CLASS_BITS-1:0] CLASS_GOOD = 2'd0;
  localparam logic [CLASS_BITS-1:0] CLASS_FAIR = 2'd1;
  localparam logic [CLASS_BITS-1:0] CLASS_BAD  = 2'd2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FAIR_THR  = 3'd0,
    REG_BAD_THR   = 3'd1,
    REG_CEILING   = 3'd2,
    REG_FAR_LIMIT = 3'd3,
    REG_NEAR_IVL  = 3'd4,
    REG_FAR_IVL   = 3'd5
  } dls_reg_e;

  typedef struct packed {
    logic                   sample_valid;
    logic [SAMPLE_BITS-1:0] sample;
  } dls_in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average;
    logic [LEVEL_BITS-1:0]  dust_level;
    logic [CLASS_BITS-1:0]  air_class;
    logic                   level_updated;
  } dls_out_t;

  typedef struct packed {
    logic start;
    logic by_ten;
  } dls_div_req_t;

endpackage

// ===== hw/rtl/dls_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, divisor is the window depth or ten.
// Depends on dls_pkg.
module dls_serial_div
  import dls_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int DW           = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dls_div_req_t  req_i,
  input  logic [DW-1:0] dividend_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int DMAX = (WINDOW_DEPTH > STEP_DIV) ? WINDOW_DEPTH : STEP_DIV;
  localparam int VW   = $clog2(DMAX + 1);
  localparam int CW   = $clog2(DW + 1);

  logic [VW-1:0] divisor_q;
  logic [VW-1:0] rem_q;
  logic [DW-1:0] num_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem_q, num_q[DW-1]};
  assign fits  = trial >= {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q     <= dividend_i;
      rem_q     <= '0;
      divisor_q <= req_i.by_ten ? VW'(STEP_DIV) : VW'(WINDOW_DEPTH);
    end else if (busy_q) begin
      rem_q <= fits ? VW'(trial - {1'b0, divisor_q}) : trial[VW-1:0];
      num_q <= {num_q[DW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

// ===== hw/rtl/dust_level_smoother_top.sv =====
// Dust level smoother: sample window, running sum, serial average and display stepping.
// Depends on dls_pkg and dls_serial_div.
//
// One transaction is taken at a time. A tick without a display update runs the sum
// update and then a divider pass for the average (SW = sum width, 14 at the default depth),
// the serial divider producing one average bit per cycle. A tick that runs the display
// update adds a shift-add multiply, the compare states S_CMP_DN and S_CMP_UP and at
// most one divider pass for the step size, since a near downward step never passes
// the target. The result sits in an output register, so the next transaction can be
// taken while it waits.
module dust_level_smoother_top
  import dls_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  dls_in_t                 in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output dls_out_t                out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [LEVEL_BITS-1:0]   cfg_data_i
);

  localparam int SW = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int DW = (SW > LEVEL_BITS) ? SW : LEVEL_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_AVG, S_MUL, S_CMP_DN, S_DIV_DN, S_CMP_UP, S_DIV_UP, S_FIN
  } state_e;

  state_e state_q;

  logic [LEVEL_BITS-1:0]  fair_q, bad_q, ceil_q, far_lim_q;
  logic [IVL_BITS-1:0]    near_ivl_q, far_ivl_q;

  logic [SAMPLE_BITS-1:0] window_q [WINDOW_DEPTH];
  logic [SW-1:0]          sum_q;
  logic [IVL_BITS-1:0]    tick_q, ivl_q;
  logic [LEVEL_BITS-1:0]  level_q, target_q;
  logic                   fire_q;
  logic [SAMPLE_BITS-1:0] avg_q;
  logic [MUL_BITS-1:0]    acc_q, addend_q;
  logic [SAMPLE_BITS-1:0] mul_sh_q;
  logic                   out_valid_q;
  dls_out_t               out_q;

  logic                   in_acc;
  logic [SAMPLE_BITS-1:0] incoming;
  logic [IVL_BITS:0]      tick_next;
  logic [LEVEL_BITS-1:0]  dn_diff, up_diff;
  logic                   dn_far, up_far;
  dls_div_req_t           div_req;
  logic [DW-1:0]          div_num;
  logic                   div_done;
  logic [DW-1:0]          div_q;
  logic [LEVEL_BITS-1:0]  gap, dec;
  logic [LEVEL_BITS:0]    up_sum;
  logic [TGT_RAW_BITS-1:0] tgt_raw;
  logic [CLASS_BITS-1:0]  cls;

  assign in_stall_o  = state_q != S_IDLE;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign incoming    = in_data_i.sample_valid ? in_data_i.sample : '0;
  assign tick_next   = {1'b0, tick_q} + 1'b1;

  assign dn_diff = level_q - target_q;
  assign up_diff = target_q - level_q;
  assign dn_far  = dn_diff > far_lim_q;
  assign up_far  = up_diff > far_lim_q;
  assign tgt_raw = acc_q[MUL_BITS-1:SCALE_SHIFT];

  // step size from the divider result, or the fixed far step
  assign gap    = LEVEL_BITS'(div_q) + 1'b1;
  assign dec    = (state_q == S_CMP_DN) ? LEVEL_BITS'(FAR_DEC) : (gap >> 1) + 1'b1;
  assign up_sum = {1'b0, level_q} +
                  ((state_q == S_CMP_UP) ? (LEVEL_BITS + 1)'(FAR_STEP) : {1'b0, gap});

  always_comb begin
    div_req = '0;
    div_num = DW'(sum_q);
    case (state_q)
      S_SUM: div_req.start = 1'b1;
      S_CMP_DN: begin
        if (level_q > target_q && !dn_far) begin
          div_req = '{start: 1'b1, by_ten: 1'b1};
          div_num = DW'(dn_diff);
        end
      end
      S_CMP_UP: begin
        if (level_q < target_q && !up_far) begin
          div_req = '{start: 1'b1, by_ten: 1'b1};
          div_num = DW'(up_diff);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (level_q > bad_q)       cls = CLASS_BAD;
    else if (level_q > fair_q) cls = CLASS_FAIR;
    else                       cls = CLASS_GOOD;
  end

  dls_serial_div #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .DW           (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_num),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fair_q     <= RST_FAIR;
      bad_q      <= RST_BAD;
      ceil_q     <= RST_CEILING;
      far_lim_q  <= RST_FAR_LIMIT;
      near_ivl_q <= RST_NEAR_IVL;
      far_ivl_q  <= RST_FAR_IVL;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (dls_reg_e'(cfg_index_i))
        REG_FAIR_THR:  fair_q     <= cfg_data_i;
        REG_BAD_THR:   bad_q      <= cfg_data_i;
        REG_CEILING:   ceil_q     <= cfg_data_i;
        REG_FAR_LIMIT: far_lim_q  <= cfg_data_i;
        REG_NEAR_IVL:  near_ivl_q <= cfg_data_i[IVL_BITS-1:0];
        REG_FAR_IVL:   far_ivl_q  <= cfg_data_i[IVL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) window_q[i] <= '0;
    end else if (in_acc) begin
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) window_q[i] <= window_q[i+1];
      window_q[WINDOW_DEPTH-1] <= incoming;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_AVG: begin
        acc_q    <= '0;
        addend_q <= MUL_BITS'(SCALE_MUL);
        mul_sh_q <= div_q[SAMPLE_BITS-1:0];
      end
      S_MUL: begin
        if (mul_sh_q[0]) acc_q <= acc_q + addend_q;
        addend_q <= addend_q << 1;
        mul_sh_q <= mul_sh_q >> 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      tick_q      <= '0;
      ivl_q       <= '0;
      level_q     <= '0;
      target_q    <= '0;
      fire_q      <= 1'b0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (state_q == S_FIN && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            sum_q   <= sum_q - SW'(window_q[0]) + SW'(incoming);
            fire_q  <= tick_next > {1'b0, ivl_q};
            tick_q  <= (tick_next > {1'b0, ivl_q}) ? '0 : tick_next[IVL_BITS-1:0];
            state_q <= S_SUM;
          end
        end
        S_SUM: state_q <= S_AVG;
        S_AVG: begin
          if (div_done) begin
            avg_q   <= div_q[SAMPLE_BITS-1:0];
            state_q <= fire_q ? S_MUL : S_FIN;
          end
        end
        S_MUL: begin
          if (mul_sh_q == '0) begin
            target_q <= (tgt_raw > TGT_RAW_BITS'(ceil_q)) ? ceil_q
                                                          : LEVEL_BITS'(tgt_raw);
            state_q  <= S_CMP_DN;
          end
        end
        S_CMP_DN: begin
          if (level_q > target_q) begin
            if (dn_far) begin
              ivl_q   <= far_ivl_q;
              level_q <= (dec > level_q) ? '0 : level_q - dec;
              state_q <= S_CMP_UP;
            end else begin
              ivl_q   <= near_ivl_q;
              state_q <= S_DIV_DN;
            end
          end else begin
            state_q <= S_CMP_UP;
          end
        end
        S_DIV_DN: begin
          if (div_done) begin
            level_q <= (dec > level_q) ? '0 : level_q - dec;
            state_q <= S_CMP_UP;
          end
        end
        S_CMP_UP: begin
          if (level_q < target_q) begin
            if (up_far) begin
              ivl_q   <= far_ivl_q;
              level_q <= up_sum[LEVEL_BITS] ? LEVEL_MAX : up_sum[LEVEL_BITS-1:0];
              state_q <= S_FIN;
            end else begin
              ivl_q   <= near_ivl_q;
              state_q <= S_DIV_UP;
            end
          end else begin
            state_q <= S_FIN;
          end
        end
        S_DIV_UP: begin
          if (div_done) begin
            level_q <= up_sum[LEVEL_BITS] ? LEVEL_MAX : up_sum[LEVEL_BITS-1:0];
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.average       <= avg_q;
            out_q.dust_level    <= level_q;
            out_q.air_class     <= cls;
            out_q.level_updated <= fire_q;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/dls_checker.sv =====
// Port-level checks for the dust level smoother, bound to the top level.
// Depends on dls_pkg and dust_level_smoother_top.
module dls_checker
  import dls_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input dls_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  a_class_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.air_class == CLASS_GOOD ||
                     out_data_o.air_class == CLASS_FAIR ||
                     out_data_o.air_class == CLASS_BAD))
    else $error("undefined air class");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");

  a_free_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result shown while still busy");

endmodule

bind dust_level_smoother_top dls_checker u_dls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
